// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands, clocked on a rising edge, off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/depq_pkg.sv =====
// ----------------------------------------------------------------------------
// depq_pkg
// Shared widths, codes and types of the double-ended priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package depq_pkg;

    localparam int VALUE_W  = 32;
    localparam int OP_W     = 2;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    typedef logic [OP_W-1:0]            t_op;
    typedef logic [STATUS_W-1:0]        t_status;
    typedef logic signed [VALUE_W-1:0]  t_value;
    typedef logic [COUNT_W-1:0]         t_count;

    localparam t_op OP_INSERT     = 2'd0;
    localparam t_op OP_REMOVE_MAX = 2'd1;
    localparam t_op OP_REMOVE_MIN = 2'd2;

    localparam t_status STAT_DONE  = 2'd0;
    localparam t_status STAT_EMPTY = 2'd1;
    localparam t_status STAT_FULL  = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage

`default_nettype wire

// ===== rtl/depq_if.sv =====
// ----------------------------------------------------------------------------
// depq_if
// Valid/ready channels: request (operation, value) and result.
// ----------------------------------------------------------------------------
`default_nettype none

interface depq_in_if import depq_pkg::*; ();
    logic   valid;
    logic   ready;
    t_op    operation;
    t_value value;

    modport source (output valid, output operation, output value, input ready);
    modport sink   (input valid, input operation, input value, output ready);
endinterface

interface depq_out_if import depq_pkg::*; ();
    logic    valid;
    logic    ready;
    t_value  max_value;
    t_value  min_value;
    t_count  entry_count;
    t_status status;

    modport source (output valid, output max_value, output min_value,
                    output entry_count, output status, input ready);
    modport sink   (input valid, input max_value, input min_value,
                    input entry_count, input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/depq_ctrl.sv =====
// ----------------------------------------------------------------------------
// depq_ctrl
// Request sequencer: capture, execute, hold result until taken.
// ----------------------------------------------------------------------------
`default_nettype none

module depq_ctrl import depq_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_rsp_valid, n_rsp_valid;
    logic   w_slot_free;

    // result register free now or drained at this edge
    assign w_slot_free = !r_rsp_valid || i_rsp_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rsp_valid <= n_rsp_valid;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_rsp_valid = r_rsp_valid && !i_rsp_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid && w_slot_free) n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state     = S_IDLE;
                n_rsp_valid = 1'b1;
            end
        endcase
    end

    always_comb begin
        o_req_ready = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_req_ready = w_slot_free;
                o_cmd.load  = i_req_valid && w_slot_free;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
        endcase
    end

    assign o_rsp_valid = r_rsp_valid;

endmodule

`default_nettype wire

// ===== rtl/depq_dp.sv =====
// ----------------------------------------------------------------------------
// depq_dp
// Two sorted cell rows holding the same multiset: the low row is packed
// at cell 0 (minimum there), the high row at the last cell (maximum there).
// ----------------------------------------------------------------------------
`default_nettype none

module depq_dp import depq_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cmd    i_cmd,
    input  t_op     i_operation,
    input  t_value  i_value,
    output t_value  o_max_value,
    output t_value  o_min_value,
    output t_count  o_entry_count,
    output t_status o_status
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    t_op              r_op;
    t_value           r_value;
    logic [CNT_W-1:0] r_count, n_count;
    t_value           r_lo [CAPACITY];
    t_value           r_hi [CAPACITY];
    t_value           n_lo [CAPACITY];
    t_value           n_hi [CAPACITY];
    t_value           r_max, r_min;
    t_count           r_ecount;
    t_status          r_status, n_status;

    logic [CAPACITY-1:0] lo_stay, hi_stay;
    logic do_ins, do_rmax, do_rmin;

    always_comb begin
        do_ins   = 1'b0;
        do_rmax  = 1'b0;
        do_rmin  = 1'b0;
        n_status = STAT_DONE;
        unique case (r_op)
            OP_INSERT: begin
                if (r_count == CAP_CNT) n_status = STAT_FULL;
                else                    do_ins   = 1'b1;
            end
            OP_REMOVE_MAX: begin
                if (r_count == '0) n_status = STAT_EMPTY;
                else               do_rmax  = 1'b1;
            end
            OP_REMOVE_MIN: begin
                if (r_count == '0) n_status = STAT_EMPTY;
                else               do_rmin  = 1'b1;
            end
            default: ;
        endcase

        n_count = r_count;
        if (do_ins)                n_count = r_count + CNT_W'(1);
        else if (do_rmax || do_rmin) n_count = r_count - CNT_W'(1);
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic   lo_edge, hi_edge;
        t_value lo_below, lo_above, hi_below, hi_above;

        // occupied cells: low row from cell 0 up, high row from the top down
        assign lo_stay[i] = (CNT_W'(i) < r_count) && !(r_value < r_lo[i]);
        assign hi_stay[i] = (CNT_W'(CAPACITY - 1 - i) < r_count) && (r_value < r_hi[i]);

        if (i == 0) begin : g_bot
            assign lo_edge  = 1'b1;
            assign lo_below = r_lo[i];
            assign hi_below = r_hi[i];
        end else begin : g_mid_lo
            assign lo_edge  = lo_stay[i-1];
            assign lo_below = r_lo[i-1];
            assign hi_below = r_hi[i-1];
        end

        if (i == CAPACITY - 1) begin : g_top
            assign hi_edge  = 1'b1;
            assign hi_above = r_hi[i];
            assign lo_above = r_lo[i];
        end else begin : g_mid_hi
            assign hi_edge  = hi_stay[i+1];
            assign hi_above = r_hi[i+1];
            assign lo_above = r_lo[i+1];
        end

        assign n_lo[i] = (do_ins && !lo_stay[i]) ? (lo_edge ? r_value : lo_below) :
                         do_rmin                 ? lo_above : r_lo[i];
        assign n_hi[i] = (do_ins && !hi_stay[i]) ? (hi_edge ? r_value : hi_above) :
                         do_rmax                 ? hi_below : r_hi[i];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= i_operation;
            r_value <= i_value;
        end
        if (i_cmd.exec) begin
            r_lo     <= n_lo;
            r_hi     <= n_hi;
            r_max    <= (n_count == '0) ? '0 : n_hi[CAPACITY-1];
            r_min    <= (n_count == '0) ? '0 : n_lo[0];
            r_ecount <= COUNT_W'(n_count);
            r_status <= n_status;
        end
    end

    assign o_max_value   = r_max;
    assign o_min_value   = r_min;
    assign o_entry_count = r_ecount;
    assign o_status      = r_status;

endmodule

`default_nettype wire

// ===== rtl/double_ended_priority_queue.sv =====
// ----------------------------------------------------------------------------
// double_ended_priority_queue
// Multiset of up to CAPACITY signed values with insert, remove-max and
// remove-min; one result (max, min, count, status) per request.
// ----------------------------------------------------------------------------
// Each request is first captured, then executed in a step in which every cell
// of two sorted register rows compares against the value and shifts by at
// most one place, so the work is one 32-bit compare plus a mux per cell
// whatever the fill level. The result is registered; the next request is
// taken while it waits, as long as the result is taken by then. Removing from
// an empty queue returns status 1, inserting into a full one returns
// status 2; both leave the contents alone, and max/min read 0 when empty.
// No clearing pass after reset: the queue is usable at once.
`default_nettype none

module double_ended_priority_queue import depq_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    depq_in_if.sink     i_req,
    depq_out_if.source  o_rsp
);

    t_cmd w_cmd;

    depq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .o_rsp_valid (o_rsp.valid),
        .i_rsp_ready (o_rsp.ready),
        .o_cmd       (w_cmd)
    );

    depq_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_operation   (i_req.operation),
        .i_value       (i_req.value),
        .o_max_value   (o_rsp.max_value),
        .o_min_value   (o_rsp.min_value),
        .o_entry_count (o_rsp.entry_count),
        .o_status      (o_rsp.status)
    );

endmodule

`default_nettype wire

// ===== rtl/depq_checker.sv =====
// ----------------------------------------------------------------------------
// depq_checker
// Port-level checks of the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module depq_checker import depq_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_req_valid,
    input logic    i_req_ready,
    input logic    i_rsp_valid,
    input t_value  i_max_value,
    input t_value  i_min_value,
    input t_count  i_entry_count,
    input t_status i_status
);

    logic w_req_acc;

    assign w_req_acc = i_req_valid && i_req_ready;

    `ASSERT_NEXT(a_rsp_follows, i_clk, i_rst_n, w_req_acc, ##1 i_rsp_valid, "result missing")
    `ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, w_req_acc, !i_req_ready, "request overlap")
    `ASSERT_IMPLY(a_order, i_clk, i_rst_n, i_rsp_valid, i_max_value >= i_min_value, "max below min")
    `ASSERT_IMPLY(a_empty_zero, i_clk, i_rst_n, i_rsp_valid && i_entry_count == '0 && CAPACITY < 128, i_max_value == '0 && i_min_value == '0, "empty not zero")
    `ASSERT_IMPLY(a_full_count, i_clk, i_rst_n, i_rsp_valid && i_status == STAT_FULL && CAPACITY < 128, i_entry_count == COUNT_W'(CAPACITY), "full flag wrong")

endmodule

bind double_ended_priority_queue depq_checker #(
    .CAPACITY (CAPACITY)
) u_depq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_rsp_valid   (o_rsp.valid),
    .i_max_value   (o_rsp.max_value),
    .i_min_value   (o_rsp.min_value),
    .i_entry_count (o_rsp.entry_count),
    .i_status      (o_rsp.status)
);

`default_nettype wire

// ===== tb/sv/double_ended_priority_queue_checker.sv =====
// ----------------------------------------------------------------------------
// double_ended_priority_queue_checker
// Watches the request and result channels of the double-ended priority queue.
// It keeps a sorted shadow copy of the stored values and works out the
// expected max, min, count and status for every accepted request. Each
// accepted result is compared field by field with the oldest expectation.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_checker import depq_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    depq_in_if   i_req,
    depq_out_if  i_rsp,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_value  max_value;
        t_value  min_value;
        t_count  entry_count;
        t_status status;
    } t_depq_result;

    t_value       sorted_vals[$];
    t_depq_result expected_results[$];
    int           fail_count = 0;
    int           pending_n  = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_n;

    task automatic report_mismatch(input string msg);
        $display("%0t ns  depq mismatch: %s", $realtime, msg);
        fail_count++;
    endtask

    // applies one request to the shadow store and returns the result it causes
    function automatic t_depq_result predict_result(input t_op op, input t_value val);
        t_depq_result res;
        int           pos;
        res.status = STAT_DONE;
        case (op)
            OP_INSERT: begin
                if (sorted_vals.size() >= CAPACITY) begin
                    res.status = STAT_FULL;
                end else begin
                    pos = sorted_vals.size();
                    while (pos > 0 && val < sorted_vals[pos-1]) pos--;
                    sorted_vals.insert(pos, val);
                end
            end
            OP_REMOVE_MAX, OP_REMOVE_MIN: begin
                if (sorted_vals.size() == 0) begin
                    res.status = STAT_EMPTY;
                end else if (op == OP_REMOVE_MAX) begin
                    void'(sorted_vals.pop_back());
                end else begin
                    void'(sorted_vals.pop_front());
                end
            end
            default: ;
        endcase
        if (sorted_vals.size() == 0) begin
            res.max_value = '0;
            res.min_value = '0;
        end else begin
            res.max_value = sorted_vals[sorted_vals.size()-1];
            res.min_value = sorted_vals[0];
        end
        res.entry_count = t_count'(sorted_vals.size());
        return res;
    endfunction

    task automatic check_result();
        t_depq_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("result with no request pending");
            return;
        end
        want = expected_results.pop_front();
        if (i_rsp.max_value !== want.max_value)
            report_mismatch($sformatf("max_value got %0d want %0d",
                                      i_rsp.max_value, want.max_value));
        if (i_rsp.min_value !== want.min_value)
            report_mismatch($sformatf("min_value got %0d want %0d",
                                      i_rsp.min_value, want.min_value));
        if (i_rsp.entry_count !== want.entry_count)
            report_mismatch($sformatf("entry_count got %0d want %0d",
                                      i_rsp.entry_count, want.entry_count));
        if (i_rsp.status !== want.status)
            report_mismatch($sformatf("status got %0d want %0d",
                                      i_rsp.status, want.status));
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            sorted_vals.delete();
            expected_results.delete();
        end else begin
            if (i_rsp.valid === 1'b1 && i_rsp.ready === 1'b1) check_result();
            if (i_req.valid === 1'b1 && i_req.ready === 1'b1)
                expected_results.insert(expected_results.size(),
                                        predict_result(i_req.operation, i_req.value));
        end
        pending_n = expected_results.size();
    end

endmodule

// ===== tb/sv/double_ended_priority_queue_tb.sv =====
// ----------------------------------------------------------------------------
// double_ended_priority_queue_tb
// Drives requests into the double-ended priority queue: a directed run over
// empty-queue removals, the unused opcode, value extremes and duplicates,
// then random fill and drain runs that reach both full and empty, under
// three sender/receiver idle mixes and one long result back-pressure.
// ----------------------------------------------------------------------------
module double_ended_priority_queue_tb import depq_pkg::*; ;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CAPACITY    = 64;
    localparam t_op OP_UNUSED   = 2'd3;
    localparam int  RUN_LEN     = 100;
    localparam int  HOLD_CYCLES = 200;
    localparam int  DIR_LEN     = 20;

    logic i_clk       = 1'b0;
    logic i_rst_n;
    logic pressure_go = 1'b0;
    logic hold_rsp;
    int   tx_idle_pct = 23;
    int   rx_idle_pct = 83;
    int   fail_count;
    int   pending;

    int tx_idle_by_phase[3] = '{23, 83, 0};
    int rx_idle_by_phase[3] = '{83, 23, 0};

    t_op dir_ops[DIR_LEN] = '{
        OP_REMOVE_MAX, OP_REMOVE_MIN, OP_UNUSED,
        OP_INSERT, OP_INSERT, OP_INSERT, OP_INSERT, OP_INSERT, OP_INSERT, OP_INSERT,
        OP_UNUSED,
        OP_REMOVE_MAX, OP_REMOVE_MAX, OP_REMOVE_MIN, OP_REMOVE_MIN,
        OP_REMOVE_MAX, OP_REMOVE_MIN, OP_REMOVE_MAX,
        OP_REMOVE_MIN, OP_REMOVE_MAX
    };
    t_value dir_vals[DIR_LEN] = '{
        32'h5a5a_a5a5, 32'hffff_ffff, 32'h1234_5678,
        32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
        32'h0000_0001, 32'h0000_0000, 32'h7fff_ffff,
        32'h8000_0000,
        32'hdead_beef, 32'h0000_0000, 32'h7fff_ffff, 32'hffff_ffff,
        32'h8000_0000, 32'h0f0f_0f0f, 32'hf0f0_f0f0,
        32'h7fff_ffff, 32'h8000_0000
    };

    depq_in_if  req_ch ();
    depq_out_if rsp_ch ();

    double_ended_priority_queue #(.CAPACITY(CAPACITY)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    double_ended_priority_queue_checker #(.CAPACITY(CAPACITY)) result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    initial begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    // result receiver
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_ch.ready <= !hold_rsp && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // long result hold-off so the queue backs up and stalls requests
    initial begin
        hold_rsp = 1'b0;
        wait (pressure_go);
        @(posedge i_clk);
        hold_rsp <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge i_clk);
        hold_rsp <= 1'b0;
    end

    function automatic t_value pick_value();
        case ($urandom_range(5))
            0:       return t_value'(32'h8000_0000);
            1:       return t_value'(32'h7fff_ffff);
            2, 3:    return t_value'($urandom_range(15)) - t_value'(8);
            default: return t_value'($urandom);
        endcase
    endfunction

    function automatic t_op pick_op(input int insert_pct);
        int r;
        r = $urandom_range(99);
        if (r < insert_pct) return OP_INSERT;
        if (r == 99)        return OP_UNUSED;
        return $urandom_range(1) ? OP_REMOVE_MAX : OP_REMOVE_MIN;
    endfunction

    // returns at the edge where the request is taken
    task automatic send_req(input t_op op, input t_value val);
        while ($urandom_range(99) < tx_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.value     <= val;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
    endtask

    initial begin
        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_INSERT;
        req_ch.value     = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_LEN; i++) send_req(dir_ops[i], dir_vals[i]);

        for (int phase = 0; phase < 3; phase++) begin
            tx_idle_pct = tx_idle_by_phase[phase];
            rx_idle_pct = rx_idle_by_phase[phase];
            if (phase == 2) pressure_go = 1'b1;
            // fill toward full, then drain toward empty
            for (int i = 0; i < RUN_LEN; i++) send_req(pick_op(90), pick_value());
            for (int i = 0; i < RUN_LEN; i++) send_req(pick_op(10), pick_value());
        end
        req_ch.valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (10) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
